>>> sv/fhss_pkg.sv
// Package for the fire heat store: beat types, controller codes and the palette.
package fhss_pkg;

  localparam int IDX_W  = 17;
  localparam int HEAT_W = 6;
  localparam int COL_W  = 24;
  localparam int CMP_W  = 26;

  localparam int DEF_WIDTH    = 320;
  localparam int DEF_HEIGHT   = 240;
  localparam int DEF_MAX_HEAT = 35;

  localparam logic       ACT_SPREAD = 1'b0;
  localparam logic       ACT_READ   = 1'b1;
  localparam logic [1:0] OFF_REJECT = 2'd3;

  localparam int PAL_TOP = 35;

  typedef struct packed {
    logic              action;
    logic [IDX_W-1:0]  pixel_index;
    logic [1:0]        rand_offset;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [HEAT_W-1:0] heat;
    logic [COL_W-1:0]  colour;
    logic              rejected;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_CALC,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic clr;
    logic latch;
    logic rd;
    logic calc;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
  } dp_status_t;

  localparam logic [COL_W-1:0] PALETTE [PAL_TOP+1] = '{
    24'h070707, 24'h1f0707, 24'h2f0f07, 24'h470f07, 24'h571707, 24'h671f07,
    24'h771f07, 24'h8f2707, 24'h9f2f07, 24'haf3f07, 24'hbf4707, 24'hc74707,
    24'hdf4f07, 24'hdf5707, 24'hdf5707, 24'hd75f07, 24'hd7670f, 24'hcf6f0f,
    24'hcf770f, 24'hcf7f0f, 24'hcf8717, 24'hc78717, 24'hc78f17, 24'hc7971f,
    24'hbf9f1f, 24'hbf9f1f, 24'hbfa727, 24'hbfa727, 24'hbfaf2f, 24'hb7af2f,
    24'hb7b72f, 24'hb7b737, 24'hcfcf6f, 24'hdfdf9f, 24'hefefc7, 24'hffffff
  };

  function automatic logic [COL_W-1:0] pal_colour(logic [HEAT_W-1:0] h);
    logic [HEAT_W-1:0] idx;
    idx = (h > HEAT_W'(PAL_TOP)) ? HEAT_W'(PAL_TOP) : h;
    return PALETTE[idx];
  endfunction

endpackage

>>> sv/fhss_ctrl.sv
// Controller state machine for the fire heat store.
module fhss_ctrl
  import fhss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       in_stall_o,
  output logic       out_valid_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (status_i.clr_done) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: state_d = ST_CALC;
      ST_CALC:  state_d = ST_OUT;
      ST_OUT:   if (!out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr = 1'b1;
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.latch = in_valid_i;
      end
      ST_CHECK: cmd_o.rd   = 1'b1;
      ST_CALC:  cmd_o.calc = 1'b1;
      ST_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> sv/fhss_datapath.sv
// Datapath for the fire heat store: heat memory, clear sweep, spread arithmetic.
module fhss_datapath
  import fhss_pkg::*;
#(
  parameter int WIDTH    = DEF_WIDTH,
  parameter int HEIGHT   = DEF_HEIGHT,
  parameter int MAX_HEAT = DEF_MAX_HEAT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  input  in_beat_t   in_data_i,
  output dp_status_t status_o,
  output out_beat_t  out_data_o
);

  localparam int FRAME  = WIDTH * HEIGHT;
  localparam int ADDR_W = $clog2(FRAME);

  logic [HEAT_W-1:0] mem [FRAME];
  logic [HEAT_W-1:0] rdata_q;

  logic [ADDR_W-1:0] clr_cnt_q;
  in_beat_t          item_q;
  logic              rej_q;
  logic [ADDR_W-1:0] dst_q;
  out_beat_t         out_q;

  logic [CMP_W-1:0]  src_w, tgt_w, dst_w;
  logic              rej_d;
  logic [ADDR_W-1:0] rd_addr;
  logic [HEAT_W-1:0] init_val, heat_d;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [HEAT_W-1:0] wr_data;
  logic              is_read;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign status_o.clr_done = (clr_cnt_q == ADDR_W'(FRAME - 1));
  assign init_val = (clr_cnt_q >= ADDR_W'(FRAME - WIDTH)) ? HEAT_W'(MAX_HEAT) : '0;

  assign is_read = (item_q.action == ACT_READ);
  assign src_w   = CMP_W'(item_q.pixel_index);
  assign rej_d   = (src_w >= CMP_W'(FRAME)) ||
                   (!is_read && ((src_w < CMP_W'(WIDTH)) ||
                                 (item_q.rand_offset == OFF_REJECT)));
  assign rd_addr = rej_d ? '0 : src_w[ADDR_W-1:0];

  assign tgt_w = src_w + CMP_W'(1) - CMP_W'(item_q.rand_offset);
  assign dst_w = ((tgt_w < CMP_W'(WIDTH)) ? CMP_W'(WIDTH) : tgt_w) - CMP_W'(WIDTH);

  always_comb begin
    heat_d = rdata_q;
    if (!is_read && item_q.rand_offset[0]) begin
      heat_d = (rdata_q != '0) ? rdata_q - 1'b1 : '0;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_q;
    wr_data = init_val;
    if (cmd_i.clr) begin
      wr_en = 1'b1;
    end else if (cmd_i.calc && !rej_q && !is_read) begin
      wr_en   = 1'b1;
      wr_addr = dst_q;
      wr_data = heat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.rd) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) item_q <= in_data_i;
    if (cmd_i.rd) begin
      rej_q <= rej_d;
      dst_q <= dst_w[ADDR_W-1:0];
    end
    if (cmd_i.calc) begin
      out_q.rejected <= rej_q;
      out_q.index    <= (rej_q || is_read) ? item_q.pixel_index : IDX_W'(dst_q);
      out_q.heat     <= rej_q ? '0 : heat_d;
      out_q.colour   <= rej_q ? '0 : pal_colour(heat_d);
    end
  end

  assign out_data_o = out_q;

endmodule

>>> sv/fire_heat_spread_store.sv
// Top level of the fire heat store: controller, datapath and checks.
// After reset the block sweeps the heat memory once over all WIDTH*HEIGHT
// addresses, loading zero everywhere and MAX_HEAT on the bottom row;
// in_stall_o stays high throughout. It then takes one beat at a time: each
// item passes through latch, memory read, compute and write back, and result,
// with the heat read through the single registered read port of the heat
// memory, and the next item is taken the cycle after the result beat leaves.
// Out-of-frame items, spreads from the top row and spreads with offset three
// come back flagged rejected with zero heat and colour.
module fire_heat_spread_store
  import fhss_pkg::*;
#(
  parameter int WIDTH    = DEF_WIDTH,
  parameter int HEIGHT   = DEF_HEIGHT,
  parameter int MAX_HEAT = DEF_MAX_HEAT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  fhss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  fhss_datapath #(
    .WIDTH    (WIDTH),
    .HEIGHT   (HEIGHT),
    .MAX_HEAT (MAX_HEAT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result beat is pending");

  a_accept_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (!out_valid_o && in_stall_o))
    else $error("result or new accept right after an accept");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.rejected) |->
      (out_data_o.heat == '0 && out_data_o.colour == '0))
    else $error("rejected beat carries heat or colour");

  a_result_heat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.rejected) |->
      (out_data_o.heat <= HEAT_W'(MAX_HEAT)))
    else $error("result heat above the maximum");

endmodule
